/* rtl/tcbcg_pkg.sv */
// Shared types and constants for the 80-column text card core.
// Used by tcbcg_ctrl, tcbcg_dp and text_card_bus_and_char_generator_core.
package tcbcg_pkg;

    // Display geometry
    localparam int TEXT_ROWS  = 25;
    localparam int CELL_LINES = 10;
    localparam int COLUMNS    = 80;

    // Widths
    localparam int ROW_W     = 8;
    localparam int LINE_W    = 4;
    localparam int ADDR_W    = 11;
    localparam int FONT_AW   = 12;
    localparam int CRTC_AW   = 6;
    localparam int SCR_DEPTH = 2**ADDR_W;

    // Scanline-to-row divide by reciprocal: ceil(2^16 / CELL_LINES)
    localparam int RECIP_FRAC = 16;
    localparam int RECIP_W    = 17;
    localparam int ROW_RECIP  = (2**RECIP_FRAC + CELL_LINES - 1) / CELL_LINES;
    localparam int PROD_W     = ROW_W + RECIP_W;

    // Bus map
    localparam logic [7:0] CTRL_OFFSET  = 8'hF6;
    localparam logic [7:0] CRTC_LIMIT   = 8'h40;
    localparam logic [7:0] CRTC_ID_REG  = 8'h3A;
    localparam logic [7:0] CRTC_ID_VAL  = 8'h01;
    localparam logic [7:0] BUS_FLOAT    = 8'hFF;

    // CRTC registers used by the character generator
    localparam logic [CRTC_AW-1:0] CRTC_START_LO   = 6'h0C;
    localparam logic [CRTC_AW-1:0] CRTC_START_HI   = 6'h0D;
    localparam logic [CRTC_AW-1:0] CRTC_SPLIT_LO   = 6'h0E;
    localparam logic [CRTC_AW-1:0] CRTC_SPLIT_HI   = 6'h0F;
    localparam logic [CRTC_AW-1:0] CRTC_SPLIT_ROW  = 6'h10;
    localparam logic [CRTC_AW-1:0] CRTC_CURSOR_ROW = 6'h18;
    localparam logic [CRTC_AW-1:0] CRTC_CURSOR_COL = 6'h19;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_FONT  = 2'd3
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic in_load;
        logic calc_en;
        logic pos_en;
        logic mem_en;
        logic font_en;
        logic out_load;
    } t_dp_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic is_fetch;
    } t_dp_stat;

endpackage

/* rtl/tcbcg_ctrl.sv */
// Sequencing state machine for the text card core.
// Depends on tcbcg_pkg; drives the tcbcg_dp command struct.
module tcbcg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  tcbcg_pkg::t_dp_stat i_stat,
    output tcbcg_pkg::t_dp_ctrl o_ctrl,
    output logic                o_in_stall,
    output logic                o_out_valid
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_POS   = 7'b0001000,
        ST_RAM   = 7'b0010000,
        ST_FONT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.in_load = 1'b1;
                    n_state        = ST_CALC;
                end
            end
            ST_CALC: begin
                o_ctrl.calc_en = 1'b1;
                n_state        = i_stat.is_fetch ? ST_POS : ST_RAM;
            end
            ST_POS: begin
                o_ctrl.pos_en = 1'b1;
                n_state       = ST_RAM;
            end
            ST_RAM: begin
                o_ctrl.mem_en = 1'b1;
                n_state       = i_stat.is_fetch ? ST_FONT : ST_DONE;
            end
            ST_FONT: begin
                o_ctrl.font_en = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                // hand the result over once the output slot is free
                if (!r_out_valid || !i_out_stall) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/tcbcg_dp.sv */
// Datapath of the text card core: request registers, screen/attribute/font
// memories, CRTC registers, address math and pixel shaping. Uses tcbcg_pkg.
module tcbcg_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcbcg_pkg::t_dp_ctrl i_ctrl,
    output tcbcg_pkg::t_dp_stat o_stat,
    input  logic [1:0]          i_command,
    input  logic                i_page,
    input  logic [7:0]          i_offset,
    input  logic [7:0]          i_data,
    input  logic [7:0]          i_scanline,
    input  logic [6:0]          i_column,
    input  logic                i_blink_phase,
    input  logic [11:0]         i_font_address,
    output logic [7:0]          o_read_data,
    output logic [7:0]          o_pixels,
    output logic [3:0]          o_colour
);

    // Request registers
    tcbcg_pkg::t_cmd r_cmd;
    logic       r_page;
    logic [7:0] r_offset;
    logic [7:0] r_data;
    logic [7:0] r_scanline;
    logic [6:0] r_column;
    logic       r_blink;
    logic [tcbcg_pkg::FONT_AW-1:0] r_font_addr;

    // Control page state
    logic [3:0] r_bank;
    logic       r_chr_off, r_attr_off, r_crtc_off;

    // CRTC shadows used by the fetch path
    logic [7:0] r_start_lo, r_start_hi, r_split_lo, r_split_hi;
    logic [7:0] r_split_row, r_cur_row, r_cur_col;

    // Clearing pass counter
    logic [tcbcg_pkg::ADDR_W-1:0] r_clr_cnt;

    // Fetch pipeline registers
    logic [tcbcg_pkg::ROW_W-1:0]  r_row;
    logic [tcbcg_pkg::LINE_W-1:0] r_line;
    logic [tcbcg_pkg::ADDR_W-1:0] r_pos;
    logic r_past, r_cursor, r_line_last;

    // Memories and their read registers
    logic [7:0] mem_scr  [tcbcg_pkg::SCR_DEPTH];
    logic [7:0] mem_attr [tcbcg_pkg::SCR_DEPTH];
    logic [7:0] mem_font [2**tcbcg_pkg::FONT_AW];
    logic [7:0] mem_crtc [2**tcbcg_pkg::CRTC_AW];
    logic [7:0] r_scr_q, r_attr_q, r_font_q, r_crtc_q;

    // Output registers
    logic [7:0] r_read_data, r_pixels;
    logic [3:0] r_colour;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_load) begin
            r_cmd       <= tcbcg_pkg::t_cmd'(i_command);
            r_page      <= i_page;
            r_offset    <= i_offset;
            r_data      <= i_data;
            r_scanline  <= i_scanline;
            r_column    <= i_column;
            r_blink     <= i_blink_phase;
            r_font_addr <= i_font_address;
        end
    end

    assign o_stat.is_fetch = (r_cmd == tcbcg_pkg::CMD_FETCH);
    assign o_stat.clr_last = (r_clr_cnt == {tcbcg_pkg::ADDR_W{1'b1}});

    // Video page window decode
    logic [tcbcg_pkg::ADDR_W-1:0] w_win_idx;
    logic w_sel_chr, w_sel_attr, w_sel_crtc;
    logic w_bus_wr, w_ctrl_wr, w_crtc_bus_we;

    assign w_win_idx  = {r_bank, r_offset[6:0]};
    assign w_sel_chr  = !r_chr_off;
    assign w_sel_attr = r_chr_off && !r_attr_off;
    assign w_sel_crtc = r_chr_off && r_attr_off && !r_crtc_off && (r_bank == 4'd0)
                        && (r_offset < tcbcg_pkg::CRTC_LIMIT);

    assign w_bus_wr      = i_ctrl.mem_en && (r_cmd == tcbcg_pkg::CMD_WRITE) && r_page;
    assign w_ctrl_wr     = i_ctrl.mem_en && (r_cmd == tcbcg_pkg::CMD_WRITE) && !r_page
                           && (r_offset == tcbcg_pkg::CTRL_OFFSET);
    assign w_crtc_bus_we = w_bus_wr && w_sel_crtc;

    // Control register at 0xF6, clearing counter, CRTC shadows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank      <= '0;
            r_chr_off   <= 1'b0;
            r_attr_off  <= 1'b0;
            r_crtc_off  <= 1'b0;
            r_clr_cnt   <= '0;
            r_start_lo  <= '0;
            r_start_hi  <= '0;
            r_split_lo  <= '0;
            r_split_hi  <= '0;
            r_split_row <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
        end else begin
            if (w_ctrl_wr) begin
                r_bank     <= r_data[3:0];
                r_chr_off  <= r_data[4];
                r_attr_off <= r_data[5];
                r_crtc_off <= r_data[6];
            end
            if (i_ctrl.clr_en) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (w_crtc_bus_we) begin
                case (r_offset[tcbcg_pkg::CRTC_AW-1:0])
                    tcbcg_pkg::CRTC_START_LO:   r_start_lo  <= r_data;
                    tcbcg_pkg::CRTC_START_HI:   r_start_hi  <= r_data;
                    tcbcg_pkg::CRTC_SPLIT_LO:   r_split_lo  <= r_data;
                    tcbcg_pkg::CRTC_SPLIT_HI:   r_split_hi  <= r_data;
                    tcbcg_pkg::CRTC_SPLIT_ROW:  r_split_row <= r_data;
                    tcbcg_pkg::CRTC_CURSOR_ROW: r_cur_row   <= r_data;
                    tcbcg_pkg::CRTC_CURSOR_COL: r_cur_col   <= r_data;
                    default: ;
                endcase
            end
        end
    end

    // Row from scanline via reciprocal multiply
    logic [tcbcg_pkg::PROD_W-1:0] w_prod;
    assign w_prod = tcbcg_pkg::PROD_W'(r_scanline)
                    * tcbcg_pkg::PROD_W'(tcbcg_pkg::ROW_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc_en) begin
            r_row <= w_prod[tcbcg_pkg::RECIP_FRAC +: tcbcg_pkg::ROW_W];
        end
    end

    // Line within cell and screen address
    logic [tcbcg_pkg::ROW_W-1:0] w_rem, w_base;
    logic        w_split_hit;
    logic [13:0] w_start;
    logic [15:0] w_pos_sum;

    assign w_rem       = r_scanline
                         - tcbcg_pkg::ROW_W'(r_row * tcbcg_pkg::ROW_W'(tcbcg_pkg::CELL_LINES));
    assign w_split_hit = (r_row >= r_split_row);
    assign w_base      = w_split_hit ? (r_row - r_split_row) : r_row;
    assign w_start     = w_split_hit ? {r_split_hi[5:0], r_split_lo}
                                     : {r_start_hi[5:0], r_start_lo};
    assign w_pos_sum   = 16'(w_base) * 16'(tcbcg_pkg::COLUMNS) + 16'(r_column) + 16'(w_start);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pos_en) begin
            r_line      <= w_rem[tcbcg_pkg::LINE_W-1:0];
            r_pos       <= w_pos_sum[tcbcg_pkg::ADDR_W-1:0];
            r_past      <= (r_row >= tcbcg_pkg::ROW_W'(tcbcg_pkg::TEXT_ROWS));
            r_cursor    <= (r_row == r_cur_row) && ({1'b0, r_column} == r_cur_col)
                           && !r_blink;
            r_line_last <= (w_rem == tcbcg_pkg::ROW_W'(tcbcg_pkg::CELL_LINES - 1));
        end
    end

    // Memory ports
    logic [tcbcg_pkg::ADDR_W-1:0]  w_ram_addr;
    logic [tcbcg_pkg::CRTC_AW-1:0] w_crtc_addr;
    logic [7:0] w_wr_data;
    logic       w_scr_we, w_attr_we, w_crtc_we, w_font_we;

    assign w_ram_addr  = i_ctrl.clr_en ? r_clr_cnt
                       : ((r_cmd == tcbcg_pkg::CMD_FETCH) ? r_pos : w_win_idx);
    assign w_crtc_addr = i_ctrl.clr_en ? r_clr_cnt[tcbcg_pkg::CRTC_AW-1:0]
                                       : r_offset[tcbcg_pkg::CRTC_AW-1:0];
    assign w_wr_data   = i_ctrl.clr_en ? 8'd0 : r_data;
    assign w_scr_we    = i_ctrl.clr_en || (w_bus_wr && w_sel_chr);
    assign w_attr_we   = i_ctrl.clr_en || (w_bus_wr && w_sel_attr);
    assign w_crtc_we   = i_ctrl.clr_en || w_crtc_bus_we;
    assign w_font_we   = i_ctrl.mem_en && (r_cmd == tcbcg_pkg::CMD_FONT);

    // Screen RAM
    always_ff @(posedge i_clk) begin
        if (w_scr_we) begin
            mem_scr[w_ram_addr] <= w_wr_data;
        end
        if (i_ctrl.mem_en) begin
            r_scr_q <= mem_scr[w_ram_addr];
        end
    end

    // Attribute RAM
    always_ff @(posedge i_clk) begin
        if (w_attr_we) begin
            mem_attr[w_ram_addr] <= w_wr_data;
        end
        if (i_ctrl.mem_en) begin
            r_attr_q <= mem_attr[w_ram_addr];
        end
    end

    // CRTC register file
    always_ff @(posedge i_clk) begin
        if (w_crtc_we) begin
            mem_crtc[w_crtc_addr] <= w_wr_data;
        end
        if (i_ctrl.mem_en) begin
            r_crtc_q <= mem_crtc[w_crtc_addr];
        end
    end

    // Font store: character code selects a 16-line block
    always_ff @(posedge i_clk) begin
        if (w_font_we) begin
            mem_font[r_font_addr] <= r_data;
        end
        if (i_ctrl.font_en) begin
            r_font_q <= mem_font[{r_scr_q, r_line}];
        end
    end

    // Pixel shaping: invert, blink, underline, cursor
    logic [7:0] w_pix;
    always_comb begin
        w_pix = r_font_q;
        if (r_attr_q[0]) begin
            w_pix = ~w_pix;
        end
        if (r_attr_q[1] && r_blink) begin
            w_pix = 8'h00;
        end
        if (r_line_last && r_attr_q[2]) begin
            w_pix = 8'hFF;
        end
        if (r_cursor) begin
            w_pix = 8'hFF;
        end
    end

    // Bus read mux
    logic [7:0] w_rd;
    always_comb begin
        if (!r_page) begin
            w_rd = tcbcg_pkg::BUS_FLOAT;
        end else if (w_sel_chr) begin
            w_rd = r_scr_q;
        end else if (w_sel_attr) begin
            w_rd = r_attr_q;
        end else if (w_sel_crtc) begin
            w_rd = (r_offset == tcbcg_pkg::CRTC_ID_REG) ? tcbcg_pkg::CRTC_ID_VAL : r_crtc_q;
        end else begin
            w_rd = tcbcg_pkg::BUS_FLOAT;
        end
    end

    // Result register; fields a command does not produce are zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            case (r_cmd)
                tcbcg_pkg::CMD_READ: begin
                    r_read_data <= w_rd;
                    r_pixels    <= 8'd0;
                    r_colour    <= 4'd0;
                end
                tcbcg_pkg::CMD_FETCH: begin
                    r_read_data <= 8'd0;
                    r_pixels    <= r_past ? 8'd0 : w_pix;
                    r_colour    <= r_past ? 4'd0 : r_attr_q[7:4];
                end
                default: begin
                    r_read_data <= 8'd0;
                    r_pixels    <= 8'd0;
                    r_colour    <= 4'd0;
                end
            endcase
        end
    end

    assign o_read_data = r_read_data;
    assign o_pixels    = r_pixels;
    assign o_colour    = r_colour;

endmodule

/* rtl/text_card_bus_and_char_generator_core.sv */
// 80-column text card core: bus window decode, CRTC registers and character
// generator. Depends on tcbcg_pkg, tcbcg_ctrl and tcbcg_dp.
//
// One request at a time. After reset the core clears screen RAM, attribute
// RAM and the 64 CRTC registers in a clearing pass and holds o_in_stall
// high meanwhile. A pixel fetch then steps through row divide, address math,
// screen/attribute read, font read and result, the font read depending on
// the screen read; bus writes, bus reads and font loads skip the address
// math and font read. The result sits in an output register, so a new request
// can be taken while the previous result is still stalled; a request only
// waits at its last step if the output register is still full.
module text_card_bus_and_char_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic        i_page,
    input  logic [7:0]  i_offset,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_scanline,
    input  logic [6:0]  i_column,
    input  logic        i_blink_phase,
    input  logic [11:0] i_font_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_pixels,
    output logic [3:0]  o_colour
);

    tcbcg_pkg::t_dp_ctrl w_ctrl;
    tcbcg_pkg::t_dp_stat w_stat;

    // Sequencer
    tcbcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath and memories
    tcbcg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_command      (i_command),
        .i_page         (i_page),
        .i_offset       (i_offset),
        .i_data         (i_data),
        .i_scanline     (i_scanline),
        .i_column       (i_column),
        .i_blink_phase  (i_blink_phase),
        .i_font_address (i_font_address),
        .o_read_data    (o_read_data),
        .o_pixels       (o_pixels),
        .o_colour       (o_colour)
    );

    // No request is taken while the memories are being cleared
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clr_en |-> o_in_stall)
        else $error("request accepted during clearing pass");

    // A result is never loaded over one that is still stalled
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // Each accepted request is followed by busy until its result is loaded
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !w_ctrl.out_load))
        else $error("core not busy after accepting a request");

endmodule

/* tb/text_card_checker.sv */
// Request monitor and result checker for the 80-column text card core.
// Depends on tcbcg_pkg; instantiated next to the core by
// tb_text_card_bus_and_char_generator_core.
`timescale 1ns / 1ps

import tcbcg_pkg::*;

module text_card_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic        i_page,
    input  logic [7:0]  i_offset,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_scanline,
    input  logic [6:0]  i_column,
    input  logic        i_blink_phase,
    input  logic [11:0] i_font_address,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic [7:0]  i_pixels,
    input  logic [3:0]  i_colour,
    output int          o_fail_count,
    output int          o_due_count
);

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pixels;
        logic [3:0] colour;
    } t_card_result;

    // Shadow of the card's memories and control register
    logic [7:0] screen_mem [SCR_DEPTH];
    logic [7:0] attr_mem   [SCR_DEPTH];
    logic [7:0] font_mem   [2**FONT_AW];
    logic [7:0] crtc_reg   [2**CRTC_AW];
    logic [3:0] bank;
    logic       char_off;
    logic       attr_off;
    logic       crtc_off;

    t_card_result results_due [$];
    int           mismatches;

    // Apply one request to the shadow state and return the result it gives
    function automatic t_card_result card_response(
        input t_cmd        cmd,
        input logic        page,
        input logic [7:0]  offset,
        input logic [7:0]  data,
        input logic [7:0]  scanline,
        input logic [6:0]  column,
        input logic        blink,
        input logic [11:0] font_addr
    );
        t_card_result res;
        logic [10:0]  win;
        int           row;
        int           cell_line;
        int           pos;
        logic [7:0]   ch;
        logic [7:0]   attr;
        logic [7:0]   glyph;
        res = '0;
        // banked window; upper half of the page mirrors the lower
        win = {bank, offset[6:0]};
        case (cmd)
            CMD_WRITE: begin
                if (page) begin
                    if (!char_off)
                        screen_mem[win] = data;
                    else if (!attr_off)
                        attr_mem[win] = data;
                    else if (!crtc_off && bank == 4'd0 && offset < CRTC_LIMIT)
                        crtc_reg[offset[5:0]] = data;
                end else if (offset == CTRL_OFFSET) begin
                    // bank in 3:0, window disables in 6:4, bit 7 unused
                    bank     = data[3:0];
                    char_off = data[4];
                    attr_off = data[5];
                    crtc_off = data[6];
                end
            end
            CMD_READ: begin
                res.read_data = BUS_FLOAT;
                if (page) begin
                    if (!char_off)
                        res.read_data = screen_mem[win];
                    else if (!attr_off)
                        res.read_data = attr_mem[win];
                    else if (!crtc_off && bank == 4'd0 && offset < CRTC_LIMIT)
                        res.read_data = (offset == CRTC_ID_REG) ? CRTC_ID_VAL
                                                                : crtc_reg[offset[5:0]];
                end
            end
            CMD_FETCH: begin
                row       = int'(scanline) / CELL_LINES;
                cell_line = int'(scanline) % CELL_LINES;
                if (row < TEXT_ROWS) begin
                    // rows from the split row on use the second start address
                    if (row >= int'(crtc_reg[CRTC_SPLIT_ROW]))
                        pos = (row - int'(crtc_reg[CRTC_SPLIT_ROW])) * COLUMNS
                            + int'(column) + int'(crtc_reg[CRTC_SPLIT_LO])
                            + (int'(crtc_reg[CRTC_SPLIT_HI][5:0]) << 8);
                    else
                        pos = row * COLUMNS + int'(column)
                            + int'(crtc_reg[CRTC_START_LO])
                            + (int'(crtc_reg[CRTC_START_HI][5:0]) << 8);
                    ch    = screen_mem[pos[10:0]];
                    attr  = attr_mem[pos[10:0]];
                    glyph = font_mem[{ch, cell_line[3:0]}];
                    if (attr[0])
                        glyph = ~glyph;
                    if (attr[1] && blink)
                        glyph = '0;
                    if (cell_line == CELL_LINES - 1 && attr[2])
                        glyph = '1;
                    if (row == int'(crtc_reg[CRTC_CURSOR_ROW])
                            && {1'b0, column} == crtc_reg[CRTC_CURSOR_COL] && !blink)
                        glyph = '1;
                    res.pixels = glyph;
                    res.colour = attr[7:4];
                end
            end
            CMD_FONT: begin
                font_mem[font_addr] = data;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Results are matched first, then the new request is predicted
    always @(posedge i_clk) begin
        t_card_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SCR_DEPTH; i++) begin
                screen_mem[i] = '0;
                attr_mem[i]   = '0;
            end
            for (int i = 0; i < 2**CRTC_AW; i++)
                crtc_reg[i] = '0;
            bank     = '0;
            char_off = 1'b0;
            attr_off = 1'b0;
            crtc_off = 1'b0;
            results_due.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result with no request pending: read_data %h pixels %h colour %h",
                           i_read_data, i_pixels, i_colour);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, i_read_data);
                        mismatches++;
                    end
                    if (i_pixels !== want.pixels) begin
                        $error("pixels: expected %h, got %h", want.pixels, i_pixels);
                        mismatches++;
                    end
                    if (i_colour !== want.colour) begin
                        $error("colour: expected %h, got %h", want.colour, i_colour);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(card_response(t_cmd'(i_command), i_page, i_offset,
                                                    i_data, i_scanline, i_column,
                                                    i_blink_phase, i_font_address));
        end
        o_fail_count <= mismatches;
        o_due_count  <= results_due.size();
    end

endmodule

/* tb/tb_text_card_bus_and_char_generator_core.sv */
// Top of the text card testbench: clock, reset, request stimulus, result stall.
// Depends on tcbcg_pkg, text_card_checker and text_card_bus_and_char_generator_core.
`timescale 1ns / 1ps

import tcbcg_pkg::*;

module tb_text_card_bus_and_char_generator_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 950;
    // character codes allowed in screen RAM; their font rows are all loaded
    localparam logic [63:0] GLYPH_SET = 64'h00FF_55AA_0FF0_3CC3;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command      = '0;
    logic        i_page         = 1'b0;
    logic [7:0]  i_offset       = '0;
    logic [7:0]  i_data         = '0;
    logic [7:0]  i_scanline     = '0;
    logic [6:0]  i_column       = '0;
    logic        i_blink_phase  = 1'b0;
    logic [11:0] i_font_address = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [7:0]  o_read_data;
    logic [7:0]  o_pixels;
    logic [3:0]  o_colour;

    int          fail_count;
    int          due_count;
    int          cycles     = 0;
    int          issued     = 0;
    logic [7:0]  ctl_shadow = '0;   // last byte written to the control register
    logic        no_idle    = 1'b0; // both sides run back to back while set

    text_card_bus_and_char_generator_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_page         (i_page),
        .i_offset       (i_offset),
        .i_data         (i_data),
        .i_scanline     (i_scanline),
        .i_column       (i_column),
        .i_blink_phase  (i_blink_phase),
        .i_font_address (i_font_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_pixels       (o_pixels),
        .o_colour       (o_colour)
    );

    text_card_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_page         (i_page),
        .i_offset       (i_offset),
        .i_data         (i_data),
        .i_scanline     (i_scanline),
        .i_column       (i_column),
        .i_blink_phase  (i_blink_phase),
        .i_font_address (i_font_address),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_read_data    (o_read_data),
        .i_pixels       (o_pixels),
        .i_colour       (o_colour),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall before each result
    initial begin
        int unsigned hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Present one request after a random gap and hold it until taken
    task automatic issue_request(input t_cmd cmd, input logic page, input logic [7:0] offset,
                                 input logic [7:0] data, input logic [7:0] scanline,
                                 input logic [6:0] column, input logic blink,
                                 input logic [11:0] font_addr);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_page         <= page;
        i_offset       <= offset;
        i_data         <= data;
        i_scanline     <= scanline;
        i_column       <= column;
        i_blink_phase  <= blink;
        i_font_address <= font_addr;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_WRITE && !page && offset == CTRL_OFFSET)
            ctl_shadow = data;
        issued++;
    endtask

    // Fields a command does not use carry random values
    task automatic bus_write(input logic page, input logic [7:0] offset, input logic [7:0] data);
        issue_request(CMD_WRITE, page, offset, data, 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                      12'($urandom_range(0, 4095)));
    endtask

    task automatic bus_read(input logic page, input logic [7:0] offset);
        issue_request(CMD_READ, page, offset, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
    endtask

    task automatic pixel_fetch(input logic [7:0] scanline, input logic [6:0] column,
                               input logic blink);
        issue_request(CMD_FETCH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), scanline, column, blink,
                      12'($urandom_range(0, 4095)));
    endtask

    task automatic font_load(input logic [11:0] font_addr, input logic [7:0] data);
        issue_request(CMD_FONT, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), data,
                      8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)), font_addr);
    endtask

    function automatic logic [7:0] random_glyph();
        return GLYPH_SET[8 * $urandom_range(0, 7) +: 8];
    endfunction

    function automatic logic [6:0] random_column();
        return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(80, 127))
                                           : 7'($urandom_range(0, 79));
    endfunction

    // Place a character and attribute in one screen slot, aim the start address
    // so that a chosen row and column land on it, then fetch some of its lines
    task automatic paint_and_fetch();
        logic [3:0]  vbank;
        logic [6:0]  slot;
        logic        spare;
        logic        mirror;
        logic [10:0] start;
        logic [4:0]  hi_junk;
        int          split;
        int          row;
        int          col;
        int          pos;
        vbank   = 4'($urandom_range(0, 15));
        slot    = 7'($urandom_range(0, 127));
        spare   = 1'($urandom_range(0, 1));
        mirror  = 1'($urandom_range(0, 1));
        hi_junk = 5'($urandom_range(0, 31));
        bus_write(1'b0, CTRL_OFFSET, {spare, 3'b000, vbank});
        bus_write(1'b1, {mirror, slot}, random_glyph());
        bus_write(1'b0, CTRL_OFFSET, {spare, 3'b001, vbank});
        bus_write(1'b1, {~mirror, slot}, 8'($urandom_range(0, 255)));
        bus_write(1'b0, CTRL_OFFSET, {spare, 3'b011, 4'h0});
        split = int'($urandom_range(0, TEXT_ROWS + 1));
        bus_write(1'b1, {2'b00, CRTC_SPLIT_ROW}, 8'(split));
        row = int'($urandom_range(0, TEXT_ROWS - 1));
        col = int'(random_column());
        pos = int'(vbank) * 128 + int'(slot);
        if (row >= split) begin
            start = 11'(pos - (row - split) * COLUMNS - col);
            bus_write(1'b1, {2'b00, CRTC_SPLIT_LO}, start[7:0]);
            bus_write(1'b1, {2'b00, CRTC_SPLIT_HI}, {hi_junk, start[10:8]});
        end else begin
            start = 11'(pos - row * COLUMNS - col);
            bus_write(1'b1, {2'b00, CRTC_START_LO}, start[7:0]);
            bus_write(1'b1, {2'b00, CRTC_START_HI}, {hi_junk, start[10:8]});
        end
        // cursor on the painted cell half of the time
        if ($urandom_range(0, 1)) begin
            bus_write(1'b1, {2'b00, CRTC_CURSOR_ROW}, 8'(row));
            bus_write(1'b1, {2'b00, CRTC_CURSOR_COL}, 8'(col));
        end
        repeat ($urandom_range(1, 4))
            pixel_fetch(8'(row * CELL_LINES + $urandom_range(0, CELL_LINES - 1)), 7'(col),
                        1'($urandom_range(0, 1)));
    endtask

    // One unstructured request of any kind
    task automatic random_request();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: pixel_fetch(8'($urandom_range(0, 255)), random_column(),
                              1'($urandom_range(0, 1)));
            2, 3: begin
                // screen RAM only ever holds characters whose font is loaded
                if (!ctl_shadow[4])
                    bus_write(1'b1, 8'($urandom_range(0, 255)), random_glyph());
                else
                    bus_write(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            4: bus_read(1'b1, 8'($urandom_range(0, 255)));
            5: begin
                if ($urandom_range(0, 3) != 0)
                    bus_write(1'b0, CTRL_OFFSET, 8'($urandom_range(0, 255)));
                else
                    bus_write(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            6: bus_read(1'b0, 8'($urandom_range(0, 255)));
            7: font_load(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
            default: begin
                case ($urandom_range(0, 2))
                    0: bus_write(1'b0, CTRL_OFFSET, {4'h3, 4'h0});
                    1: bus_write(1'b0, CTRL_OFFSET, {4'h1, 4'($urandom_range(0, 15))});
                    default: bus_write(1'b0, CTRL_OFFSET, {4'h0, 4'($urandom_range(0, 15))});
                endcase
            end
        endcase
    endtask

    initial begin
        int base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: font rows used below are loaded before any fetch
        font_load(12'h000, 8'hA5);
        font_load(12'h009, 8'h3C);
        font_load(12'hFFF, 8'hFF);
        bus_read(1'b0, CTRL_OFFSET);           // control page floats
        bus_read(1'b1, 8'hFF);                 // cleared screen RAM, upper half mirror
        pixel_fetch(8'd0, 7'd0, 1'b0);         // cursor at home after reset
        pixel_fetch(8'd0, 7'd0, 1'b1);         // cursor hidden in blink-off phase
        bus_write(1'b0, CTRL_OFFSET, 8'h10);   // attribute window, bank 0
        bus_write(1'b1, 8'h81, 8'hF7);         // invert, blink, underline, colour 15
        bus_read(1'b1, 8'h01);
        pixel_fetch(8'd9, 7'd1, 1'b0);         // underline on last cell line
        pixel_fetch(8'd0, 7'd1, 1'b1);         // blanked by blink
        pixel_fetch(8'd0, 7'd1, 1'b0);         // inverted
        bus_write(1'b0, CTRL_OFFSET, 8'hB0);   // CRTC window, bit 7 ignored
        bus_write(1'b1, CRTC_ID_REG, 8'h55);
        bus_read(1'b1, CRTC_ID_REG);           // ID register is fixed
        bus_write(1'b1, CRTC_LIMIT, 8'h12);    // past the register file
        bus_read(1'b1, CRTC_LIMIT);
        bus_write(1'b1, {2'b00, CRTC_CURSOR_ROW}, 8'd24);
        bus_write(1'b1, {2'b00, CRTC_CURSOR_COL}, 8'd79);
        pixel_fetch(8'd249, 7'd79, 1'b0);      // cursor on last row and column
        pixel_fetch(8'd250, 7'd0, 1'b0);       // rows past the last
        pixel_fetch(8'd255, 7'd127, 1'b1);
        bus_write(1'b0, CTRL_OFFSET, 8'h31);   // CRTC window outside bank 0
        bus_read(1'b1, 8'h00);
        bus_write(1'b0, CTRL_OFFSET, 8'h7F);   // every window off
        bus_read(1'b1, 8'h80);
        bus_write(1'b0, 8'h00, 8'hFF);         // other control offsets do nothing
        bus_write(1'b0, CTRL_OFFSET, 8'h00);

        // Font rows for every character that may be placed in screen RAM
        for (int k = 0; k < 8; k++)
            for (int ln = 0; ln < CELL_LINES; ln++)
                font_load(12'(GLYPH_SET[8 * k +: 8] * 16 + ln), 8'($urandom_range(0, 255)));

        // Random: mostly painted cells with fetches, some stray requests
        base = issued;
        while (issued - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                no_idle = ~no_idle;
            if ($urandom_range(0, 9) < 6)
                paint_and_fetch();
            else
                random_request();
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        do @(posedge i_clk); while (due_count != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
